// ----- design/swmf_pkg.sv -----
// ----------------------------------------------------------------------------
// swmf_pkg - shared types and constants of the running median filter
// Window size, field widths, cell link type and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package swmf_pkg;

	localparam int WINDOW_SIZE = 32;
	localparam int SAMPLE_W    = 10;
	localparam int REF_W       = 16;
	localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int PROD_W      = SAMPLE_W + REF_W;
	localparam int SCALE_SHIFT = 10;
	localparam logic [REF_W-1:0] REF_RESET = REF_W'(5000);

	typedef logic [SAMPLE_W-1:0] sample_t;

	// What one cell shows its neighbours
	typedef struct packed {
		sample_t val;    // stored value
		logic    le_r;   // stored value <= value being dropped
		logic    rle_x;  // value this cell keeps after the drop <= new sample
	} cell_link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SHIFT,
		ST_SCALE,
		ST_PUSH
	} state_t;

endpackage

`default_nettype wire

// ----- design/swmf_cell.sv -----
// ----------------------------------------------------------------------------
// swmf_cell - one slot of the sorted window
// Drops the outgoing sample and inserts the new one by looking only at its
// two neighbours; the row of cells stays sorted in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   upd,      // drop r, insert x this cycle
	input  wire                   top_cell, // no neighbour above
	input  swmf_pkg::sample_t     x,        // new sample
	input  swmf_pkg::sample_t     r,        // sample leaving the window
	input  swmf_pkg::cell_link_t  lo,       // neighbour below
	input  swmf_pkg::cell_link_t  hi,       // neighbour above
	output swmf_pkg::cell_link_t  link
);

	swmf_pkg::sample_t val_q;
	swmf_pkg::sample_t kept;   // this slot after the drop
	swmf_pkg::sample_t kept_lo; // slot below after the drop
	swmf_pkg::sample_t nxt;
	logic              le_r;
	logic              rle_x;

	always_comb begin
		le_r    = (val_q <= r);
		// Below the dropped entry keep own value, at or above it take the upper one
		kept    = hi.le_r ? val_q : hi.val;
		kept_lo = le_r ? lo.val : val_q;
		rle_x   = top_cell ? 1'b0 : (kept <= x);
		if (rle_x) begin
			nxt = kept;
		end else if (lo.rle_x) begin
			nxt = x;
		end else begin
			nxt = kept_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (upd) begin
			val_q <= nxt;
		end
	end

	assign link = '{val: val_q, le_r: le_r, rle_x: rle_x};

endmodule

`default_nettype wire

// ----- design/swmf_ring.sv -----
// ----------------------------------------------------------------------------
// swmf_ring - arrival-order store of the window
// Keeps samples in arrival order so the oldest one is known when it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module swmf_ring (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr,
	input  swmf_pkg::sample_t wdata,
	output swmf_pkg::sample_t oldest
);

	swmf_pkg::sample_t            mem [swmf_pkg::WINDOW_SIZE];
	swmf_pkg::sample_t            rd_q;
	logic [swmf_pkg::SLOT_W-1:0]  slot_q;
	logic                         wrapped_q;
	logic                         last_slot;

	assign last_slot = (slot_q == swmf_pkg::SLOT_W'(swmf_pkg::WINDOW_SIZE - 1));

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[slot_q] <= wdata;
		end
		rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			wrapped_q <= 1'b0;
		end else if (wr) begin
			slot_q <= last_slot ? '0 : slot_q + 1'b1;
			if (last_slot) begin
				wrapped_q <= 1'b1;
			end
		end
	end

	// Until the first wrap the oldest value reads as zero, the value the cells reset to
	assign oldest = wrapped_q ? rd_q : '0;

endmodule

`default_nettype wire

// ----- design/sliding_window_median_filter.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_filter - running median of converter samples
// Sorted chain of cells holding the window, arrival-order ring to find the
// sample that leaves, median taken from the middle cells and scaled to mV.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata: sample; tuser: sample_valid, report
//  m_      | out | m_tvalid/m_tready  | tdata: median_sample, median_mv
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data: reference_mv
//
//  An item passes from its transfer through the read of the oldest sample
//  from the ring memory port, the drop and insert in the cell row, the median
//  and the 10x16 scaling multiply, and the load of the output register;
//  without a report it ends after the drop and insert. A new item is taken
//  only once the sequence is back in idle. The result is offered from the
//  cycle after the load. A result waiting in the output register stalls only
//  that last step, and with it the input. Reset clears the cells and ring
//  pointer at once; no clearing pass is needed. Configuration is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_filter (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [9:0] sample, rest zero
	input  wire  [1:0]  s_tuser,   // [0] sample_valid, [1] report
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,   // [9:0] median_sample, [25:10] median_mv
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data   // reference_mv
);

	localparam int N = swmf_pkg::WINDOW_SIZE;

	swmf_pkg::state_t              state_q;
	swmf_pkg::state_t              state_nxt;
	swmf_pkg::sample_t             x_q;
	logic                          sv_q;
	logic                          rep_q;
	logic [swmf_pkg::REF_W-1:0]    ref_q;
	swmf_pkg::sample_t             med_q;
	logic [swmf_pkg::PROD_W-1:0]   prod_q;
	logic                          m_tvalid_q;
	logic [31:0]                   m_tdata_q;
	swmf_pkg::sample_t             oldest;
	swmf_pkg::sample_t             med;
	swmf_pkg::cell_link_t          link [N];
	logic                          upd;
	logic                          load;
	logic                          s_xfer;
	logic [N-2:0]                  ordered;

	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Reference register: take every configuration transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= swmf_pkg::REF_RESET;
		end else if (cfg_valid) begin
			ref_q <= cfg_data;
		end
	end

	// Hold the accepted item for the whole sequence
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			x_q   <= s_tdata[swmf_pkg::SAMPLE_W-1:0];
			sv_q  <= s_tuser[0];
			rep_q <= s_tuser[1];
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			swmf_pkg::ST_IDLE:  if (s_tvalid) state_nxt = swmf_pkg::ST_READ;
			swmf_pkg::ST_READ:  state_nxt = swmf_pkg::ST_SHIFT;
			swmf_pkg::ST_SHIFT: state_nxt = rep_q ? swmf_pkg::ST_SCALE : swmf_pkg::ST_IDLE;
			swmf_pkg::ST_SCALE: state_nxt = swmf_pkg::ST_PUSH;
			swmf_pkg::ST_PUSH:  if (!m_tvalid_q || m_tready) state_nxt = swmf_pkg::ST_IDLE;
			default:            state_nxt = swmf_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		upd      = 1'b0;
		load     = 1'b0;
		case (state_q)
			swmf_pkg::ST_IDLE:  s_tready = 1'b1;
			swmf_pkg::ST_SHIFT: upd = sv_q;
			swmf_pkg::ST_PUSH:  load = !m_tvalid_q || m_tready;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Ring memory: tells the cells which value leaves the window
	swmf_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (upd),
		.wdata  (x_q),
		.oldest (oldest)
	);

	// Sorted cell row, lowest value in cell 0
	for (genvar i = 0; i < N; i++) begin : g_cell
		swmf_pkg::cell_link_t lo_link;
		swmf_pkg::cell_link_t hi_link;
		if (i == 0) begin : g_lo_edge
			assign lo_link = '{val: '0, le_r: 1'b1, rle_x: 1'b1};
		end else begin : g_lo
			assign lo_link = link[i-1];
		end
		if (i == N - 1) begin : g_hi_edge
			assign hi_link = '{val: '0, le_r: 1'b0, rle_x: 1'b0};
		end else begin : g_hi
			assign hi_link = link[i+1];
		end
		swmf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.top_cell (i == N - 1),
			.x        (x_q),
			.r        (oldest),
			.lo       (lo_link),
			.hi       (hi_link),
			.link     (link[i])
		);
	end

	// Median straight from the middle cells
	if ((N % 2) != 0) begin : g_odd
		assign med = link[(N-1)/2].val;
	end else begin : g_even
		logic [swmf_pkg::SAMPLE_W:0] mid_sum;
		assign mid_sum = {1'b0, link[N/2].val} + {1'b0, link[N/2-1].val};
		assign med     = mid_sum[swmf_pkg::SAMPLE_W:1];
	end

	// Scale: one 10x16 product, registered
	always_ff @(posedge clk) begin
		if (state_q == swmf_pkg::ST_SCALE) begin
			med_q  <= med;
			prod_q <= swmf_pkg::PROD_W'(med) * swmf_pkg::PROD_W'(ref_q);
		end
	end

	// Output register: advance on load, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {6'd0, prod_q[swmf_pkg::PROD_W-1:swmf_pkg::SCALE_SHIFT], med_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	for (genvar i = 0; i < N - 1; i++) begin : g_ord
		assign ordered[i] = (link[i].val <= link[i+1].val);
	end

	// The row must stay sorted whenever it is at rest
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swmf_pkg::ST_IDLE) |-> (&ordered))
		else $error("cell row out of order");

	// A waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!m_tvalid_q || m_tready))
		else $error("output register overwritten");

	// A transfer always starts the ring read
	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> (state_q == swmf_pkg::ST_READ))
		else $error("accepted item did not start sequence");

	// An item without a report yields nothing and frees the block
	a_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == swmf_pkg::ST_SHIFT && !rep_q) |=> (state_q == swmf_pkg::ST_IDLE))
		else $error("item without report did not return to idle");

endmodule

`default_nettype wire
